>>> hdl/laplacian_stencil_3d_7pt_top_macros.svh
// laplacian_stencil_3d_7pt_top_macros.svh: assertion helpers for the stencil top level
// no dependencies; included by the top level only
`ifndef LAPLACIAN_STENCIL_3D_7PT_TOP_MACROS_SVH
`define LAPLACIAN_STENCIL_3D_7PT_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define LAP3D_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil check failed");

// next-cycle implication, checked on every rising edge outside reset
`define LAP3D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil check failed");

`endif

>>> hdl/lap3d_pkg.sv
// lap3d_pkg: shared types and constants of the seven-point 3d stencil
// no dependencies; imported by every module of the block
package lap3d_pkg;

    // result width, signed q11.16
    localparam int OUT_BITS = 27;

    // result queue depth, power of two
    localparam int OQ_DEPTH = 4;

    // configuration register indexes (byte address 4*index)
    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } t_reg_idx;

    // position flags of the sample being accepted
    typedef struct packed {
        logic interior;
        logic last;
        logic col_odd;
        logic plane_odd;
    } t_pos_ctl;

    // one result beat
    typedef struct packed {
        logic signed [OUT_BITS-1:0] laplacian;
        logic                       last;
    } t_result;

endpackage

>>> hdl/lap3d_pos.sv
// lap3d_pos: position counters, size clamping and plane store addressing
// depends on lap3d_pkg
module lap3d_pos #(
    parameter int MAX_X = 128,
    parameter int MAX_Y = 128,
    parameter int MAX_Z = 128,
    parameter int ZW    = 65,
    parameter int AW    = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_volume_start,
    input  logic [7:0]          i_size_x,
    input  logic [7:0]          i_size_y,
    input  logic [7:0]          i_size_z,
    output logic [AW-1:0]       o_addr_a_mid,
    output logic [AW-1:0]       o_addr_a_up,
    output logic [AW-1:0]       o_addr_b_mid,
    output logic [AW-1:0]       o_addr_b_dn,
    output lap3d_pkg::t_pos_ctl o_ctl
);
    import lap3d_pkg::*;

    localparam int PW  = $clog2(MAX_X);
    localparam int RW  = $clog2(MAX_Y);
    localparam int CW  = $clog2(MAX_Z);
    localparam int SXW = $clog2(MAX_X + 1) + 1;
    localparam int SYW = $clog2(MAX_Y + 1) + 1;
    localparam int SZW = $clog2(MAX_Z + 1) + 1;
    localparam int KW  = $clog2(ZW);

    logic [PW-1:0]  r_plane, n_plane;
    logic [RW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_col, n_col;

    logic [SXW-1:0] sx, pe;
    logic [SYW-1:0] sy, re;
    logic [SZW-1:0] sz, ce;
    logic [PW-1:0]  p;
    logic [RW-1:0]  r, row_up, row_dn;
    logic [CW-1:0]  c;
    logic [KW-1:0]  ka, kb;
    logic           interior;

    // effective sizes: below 3 acts as 3, above the maximum as the maximum
    always_comb begin
        if (i_size_x < 8'd3) begin
            sx = SXW'(3);
        end else if (32'(i_size_x) > MAX_X) begin
            sx = SXW'(MAX_X);
        end else begin
            sx = SXW'(i_size_x);
        end
        if (i_size_y < 8'd3) begin
            sy = SYW'(3);
        end else if (32'(i_size_y) > MAX_Y) begin
            sy = SYW'(MAX_Y);
        end else begin
            sy = SYW'(i_size_y);
        end
        if (i_size_z < 8'd3) begin
            sz = SZW'(3);
        end else if (32'(i_size_z) > MAX_Z) begin
            sz = SZW'(MAX_Z);
        end else begin
            sz = SZW'(i_size_z);
        end
    end

    // position of this sample, volume start forces the origin
    always_comb begin
        p  = i_volume_start ? '0 : r_plane;
        r  = i_volume_start ? '0 : r_row;
        c  = i_volume_start ? '0 : r_col;
        pe = SXW'(p);
        re = SYW'(r);
        ce = SZW'(c);
    end

    assign interior = (pe >= SXW'(2)) && (pe + SXW'(1) <= sx) &&
                      (re >= SYW'(1)) && (re + SYW'(2) <= sy) &&
                      (ce >= SZW'(1)) && (ce + SZW'(2) <= sz);

    always_comb begin
        o_ctl.interior  = interior;
        o_ctl.last      = (pe + SXW'(1) == sx) && (re + SYW'(2) == sy) &&
                          (ce + SZW'(2) == sz);
        o_ctl.col_odd   = c[0];
        o_ctl.plane_odd = p[0];
    end

    // raster advance with wrap on the current sizes
    always_comb begin
        n_plane = p;
        n_row   = r;
        n_col   = c;
        if (ce + SZW'(1) >= sz) begin
            n_col = '0;
            if (re + SYW'(1) >= sy) begin
                n_row = '0;
                if (pe + SXW'(1) >= sx) begin
                    n_plane = '0;
                end else begin
                    n_plane = PW'(pe + SXW'(1));
                end
            end else begin
                n_row = RW'(re + SYW'(1));
            end
        end else begin
            n_col = CW'(ce + SZW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else if (i_adv) begin
            r_plane <= n_plane;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // bank a pairs columns (2k, 2k+1), bank b pairs (2k-1, 2k)
    always_comb begin
        row_up = interior ? RW'(r - 1'b1) : r;
        row_dn = interior ? RW'(r + 1'b1) : r;
        ka     = KW'(c >> 1);
        kb     = KW'((SZW'(c) + SZW'(1)) >> 1);
        o_addr_a_mid = AW'(32'(r) * ZW + 32'(ka));
        o_addr_a_up  = AW'(32'(row_up) * ZW + 32'(ka));
        o_addr_b_mid = AW'(32'(r) * ZW + 32'(kb));
        o_addr_b_dn  = AW'(32'(row_dn) * ZW + 32'(kb));
    end

endmodule

>>> hdl/lap3d_store.sv
// lap3d_store: two-bank plane store with neighbor selection
// depends on lap3d_pkg; words hold two columns of both plane parities
module lap3d_store #(
    parameter int SAMPLE_BITS = 24,
    parameter int DEPTH       = 8320,
    parameter int AW          = 14
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  lap3d_pkg::t_pos_ctl           i_ctl,
    input  logic [AW-1:0]                 i_addr_a_mid,
    input  logic [AW-1:0]                 i_addr_a_up,
    input  logic [AW-1:0]                 i_addr_b_mid,
    input  logic [AW-1:0]                 i_addr_b_dn,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_centre,
    output logic signed [SAMPLE_BITS-1:0] o_prev,
    output logic signed [SAMPLE_BITS-1:0] o_up,
    output logic signed [SAMPLE_BITS-1:0] o_down,
    output logic signed [SAMPLE_BITS-1:0] o_left,
    output logic signed [SAMPLE_BITS-1:0] o_right
);
    import lap3d_pkg::*;

    // lane index is {column lane, plane parity}
    typedef logic [3:0][SAMPLE_BITS-1:0] t_word;

    t_word r_mem_a [DEPTH];
    t_word r_mem_b [DEPTH];
    t_word r_rd_a_mid, r_rd_a_up, r_rd_b_mid, r_rd_b_dn;
    logic  r_col_odd, r_plane_odd;
    logic  cur, old;

    // read before write: the old plane p-2 entry is returned as it is replaced
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_a_mid <= r_mem_a[i_addr_a_mid];
            r_rd_a_up  <= r_mem_a[i_addr_a_up];
            r_mem_a[i_addr_a_mid][{i_ctl.col_odd, i_ctl.plane_odd}] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_b_mid <= r_mem_b[i_addr_b_mid];
            r_rd_b_dn  <= r_mem_b[i_addr_b_dn];
            r_mem_b[i_addr_b_mid][{~i_ctl.col_odd, i_ctl.plane_odd}] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col_odd   <= i_ctl.col_odd;
            r_plane_odd <= i_ctl.plane_odd;
        end
    end

    // cur: parity of the centre plane, old: parity of the plane before it
    assign cur = ~r_plane_odd;
    assign old = r_plane_odd;

    always_comb begin
        if (!r_col_odd) begin
            o_centre = $signed(r_rd_a_mid[{1'b0, cur}]);
            o_prev   = $signed(r_rd_a_mid[{1'b0, old}]);
            o_right  = $signed(r_rd_a_mid[{1'b1, cur}]);
            o_left   = $signed(r_rd_b_mid[{1'b0, cur}]);
        end else begin
            o_centre = $signed(r_rd_a_mid[{1'b1, cur}]);
            o_prev   = $signed(r_rd_a_mid[{1'b1, old}]);
            o_left   = $signed(r_rd_a_mid[{1'b0, cur}]);
            o_right  = $signed(r_rd_b_mid[{1'b1, cur}]);
        end
        o_up   = $signed(r_rd_a_up[{r_col_odd, cur}]);
        o_down = $signed(r_rd_b_dn[{~r_col_odd, cur}]);
    end

endmodule

>>> hdl/lap3d_alu.sv
// lap3d_alu: two-stage stencil sum with saturation to q11.16
// depends on lap3d_pkg
module lap3d_alu #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  lap3d_pkg::t_pos_ctl           i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_centre,
    input  logic signed [SAMPLE_BITS-1:0] i_prev,
    input  logic signed [SAMPLE_BITS-1:0] i_up,
    input  logic signed [SAMPLE_BITS-1:0] i_down,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    output logic                          o_valid,
    output lap3d_pkg::t_result            o_result,
    output logic [1:0]                    o_pending
);
    import lap3d_pkg::*;

    localparam int SUMW = SAMPLE_BITS + 2;
    localparam int C6W  = SAMPLE_BITS + 3;
    localparam int ACW  = (SAMPLE_BITS + 4 > OUT_BITS + 1) ? SAMPLE_BITS + 4 : OUT_BITS + 1;
    localparam logic signed [ACW-1:0] SAT_HI =
        {{(ACW - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}};
    localparam logic signed [ACW-1:0] SAT_LO =
        {{(ACW - OUT_BITS + 1){1'b1}}, {(OUT_BITS - 1){1'b0}}};

    logic                          r_v1, r_v2, r_last1, r_last2;
    logic signed [SAMPLE_BITS-1:0] r_s1;
    logic signed [SUMW-1:0]        r_sum_a, r_sum_b, n_sum_a, n_sum_b;
    logic signed [C6W-1:0]         r_c6, n_c6;
    logic signed [ACW-1:0]         acc, sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_en && i_ctl.interior;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1    <= i_sample;
            r_last1 <= i_ctl.last;
        end
    end

    // stage one: two partial sums of three and the scaled centre
    always_comb begin
        n_sum_a = SUMW'(i_prev) + SUMW'(r_s1) + SUMW'(i_up);
        n_sum_b = SUMW'(i_down) + SUMW'(i_left) + SUMW'(i_right);
        n_c6    = (C6W'(i_centre) <<< 2) + (C6W'(i_centre) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_sum_a <= n_sum_a;
        r_sum_b <= n_sum_b;
        r_c6    <= n_c6;
        r_last2 <= r_last1;
    end

    // stage two: final add and clamp
    always_comb begin
        acc = ACW'(r_sum_a) + ACW'(r_sum_b) - ACW'(r_c6);
        if (acc > SAT_HI) begin
            sat = SAT_HI;
        end else if (acc < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = acc;
        end
    end

    always_comb begin
        o_result.laplacian = sat[OUT_BITS-1:0];
        o_result.last      = r_last2;
    end

    assign o_valid   = r_v2;
    assign o_pending = {1'b0, r_v1} + {1'b0, r_v2};

endmodule

>>> hdl/lap3d_oq.sv
// lap3d_oq: small result queue between the datapath and the output channel
// depends on lap3d_pkg
module lap3d_oq (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_wr,
    input  lap3d_pkg::t_result                           i_data,
    input  logic                                         i_stall,
    output logic                                         o_valid,
    output lap3d_pkg::t_result                           o_data,
    output logic [$clog2(lap3d_pkg::OQ_DEPTH + 1)-1:0]   o_count
);
    import lap3d_pkg::*;

    localparam int PTRW = $clog2(OQ_DEPTH);
    localparam int CNTW = $clog2(OQ_DEPTH + 1);

    t_result         r_q [OQ_DEPTH];
    logic [PTRW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic            pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/laplacian_stencil_3d_7pt_top.sv
// laplacian_stencil_3d_7pt_top: streaming seven-point 3d laplacian, apb size registers
// depends on lap3d_pkg, lap3d_pos, lap3d_store, lap3d_alu, lap3d_oq and the macros header
// a result beat passes the store read registers, alu sum registers and result queue
// throughput: one sample beat per cycle unless stalled, one plane store pass per sample
// o_stall rises in reset or when the 4-entry queue plus results in flight would be full
// reset: sync active low; counters zero, sizes 128, plane store left as is (no clearing)
`include "laplacian_stencil_3d_7pt_top_macros.svh"

module laplacian_stencil_3d_7pt_top #(
    parameter int MAX_X       = 128,
    parameter int MAX_Y       = 128,
    parameter int MAX_Z       = 128,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic                                 i_volume_start,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [lap3d_pkg::OUT_BITS-1:0] o_laplacian,
    output logic                                 o_last_of_volume,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import lap3d_pkg::*;

    // plane store geometry: each row holds ZW two-column words per bank
    localparam int ZW    = MAX_Z / 2 + 1;
    localparam int DEPTH = MAX_Y * ZW;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(OQ_DEPTH + 1);
    localparam int OSW   = CNTW + 1;

    logic [7:0]             r_size_x, r_size_y, r_size_z;
    logic                   in_acc;
    t_pos_ctl               pos_ctl;
    logic [AW-1:0]          addr_a_mid, addr_a_up, addr_b_mid, addr_b_dn;
    logic signed [SAMPLE_BITS-1:0] nb_centre, nb_prev, nb_up, nb_down, nb_left, nb_right;
    logic                   alu_valid;
    t_result                alu_result;
    logic [1:0]             pending;
    t_result                oq_data;
    logic [CNTW-1:0]        oq_count;
    logic [OSW-1:0]         outstanding;

    // ------------------------------------------------------------------
    // configuration registers, written on the access phase
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 8'd128;
            r_size_y <= 8'd128;
            r_size_z <= 8'd128;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_SIZE_X: r_size_x <= pwdata[7:0];
                REG_SIZE_Y: r_size_y <= pwdata[7:0];
                REG_SIZE_Z: r_size_z <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_SIZE_X: prdata = {24'd0, r_size_x};
            REG_SIZE_Y: prdata = {24'd0, r_size_y};
            REG_SIZE_Z: prdata = {24'd0, r_size_z};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input flow control: credit over the result queue
    // every interior sample takes one queue slot from acceptance until its
    // result leaves; boundary samples produce nothing and take no slot
    // ------------------------------------------------------------------
    assign outstanding = OSW'(oq_count) + OSW'(pending);
    assign o_stall     = !i_rst_n || (outstanding >= OSW'(OQ_DEPTH));
    assign in_acc      = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // position tracking and store addressing for the current sample
    // the centre point lags one plane behind the arriving sample
    // ------------------------------------------------------------------
    lap3d_pos #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z),
        .ZW    (ZW),
        .AW    (AW)
    ) u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (in_acc),
        .i_volume_start (i_volume_start),
        .i_size_x       (r_size_x),
        .i_size_y       (r_size_y),
        .i_size_z       (r_size_z),
        .o_addr_a_mid   (addr_a_mid),
        .o_addr_a_up    (addr_a_up),
        .o_addr_b_mid   (addr_b_mid),
        .o_addr_b_dn    (addr_b_dn),
        .o_ctl          (pos_ctl)
    );

    // ------------------------------------------------------------------
    // plane store: two banks, each read at two addresses and written once
    // per accepted sample; the write replaces the plane two back, whose
    // old value is the far neighbor and comes out of the same read
    // ------------------------------------------------------------------
    lap3d_store #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DEPTH       (DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk        (i_clk),
        .i_en         (in_acc),
        .i_ctl        (pos_ctl),
        .i_addr_a_mid (addr_a_mid),
        .i_addr_a_up  (addr_a_up),
        .i_addr_b_mid (addr_b_mid),
        .i_addr_b_dn  (addr_b_dn),
        .i_sample     (i_sample),
        .o_centre     (nb_centre),
        .o_prev       (nb_prev),
        .o_up         (nb_up),
        .o_down       (nb_down),
        .o_left       (nb_left),
        .o_right      (nb_right)
    );

    // ------------------------------------------------------------------
    // arithmetic: partial sums, then final add with clamp to 27 bits
    // ------------------------------------------------------------------
    lap3d_alu #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_alu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (in_acc),
        .i_ctl     (pos_ctl),
        .i_sample  (i_sample),
        .i_centre  (nb_centre),
        .i_prev    (nb_prev),
        .i_up      (nb_up),
        .i_down    (nb_down),
        .i_left    (nb_left),
        .i_right   (nb_right),
        .o_valid   (alu_valid),
        .o_result  (alu_result),
        .o_pending (pending)
    );

    // ------------------------------------------------------------------
    // result queue decouples the datapath from output stalls
    // ------------------------------------------------------------------
    lap3d_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (alu_valid),
        .i_data  (alu_result),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (oq_data),
        .o_count (oq_count)
    );

    assign o_laplacian      = oq_data.laplacian;
    assign o_last_of_volume = oq_data.last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // credit scheme never lets results in flight exceed the queue
    `LAP3D_ASSERT_IMPL(a_queue_room, i_clk, i_rst_n, 1'b1, outstanding <= OSW'(OQ_DEPTH))
    // an accepted interior sample is tracked as a pending result
    `LAP3D_ASSERT_NEXT(a_result_tracked, i_clk, i_rst_n, in_acc && pos_ctl.interior, pending != 2'd0)
    // with nothing queued or in flight the sample channel is open
    `LAP3D_ASSERT_IMPL(a_idle_open, i_clk, i_rst_n, (oq_count == '0) && (pending == 2'd0), !o_stall)

endmodule

>>> bench/tb.sv
// tb: self-checking bench for laplacian_stencil_3d_7pt_top, streams volumes and checks every beat
// depends on lap3d_pkg and the top level; keeps its own plane store to predict each laplacian
module tb;
    import lap3d_pkg::*;

    // block parameters as instantiated (defaults of the top level)
    localparam int MAX_X       = 128;
    localparam int MAX_Y       = 128;
    localparam int MAX_Z       = 128;
    localparam int SAMPLE_BITS = 24;
    localparam int PLANE_WORDS = MAX_Y * MAX_Z;

    localparam longint LAP_MAX = (longint'(1) << (OUT_BITS - 1)) - 1;
    localparam longint LAP_MIN = -(longint'(1) << (OUT_BITS - 1));
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // pipeline latency of the block, waited out with margin
    localparam int SETTLE_CYCLES = 10;
    // watchdog limit on the whole run
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          volume_start;
    } t_sample_beat;

    // clock, reset and block ports; those the bench drives are known from time zero
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          i_volume_start = 1'b0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [OUT_BITS-1:0]    o_laplacian;
    logic                          o_last_of_volume;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [3:0]                    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // shadow state of the block: two planes, position and size registers
    logic signed [SAMPLE_BITS-1:0] plane_mem [0:2*PLANE_WORDS-1];
    int unsigned                   cur_plane = 0;
    int unsigned                   cur_row = 0;
    int unsigned                   cur_col = 0;
    logic [7:0]                    size_reg [3] = '{8'd128, 8'd128, 8'd128};

    // beats waiting to be sent, beats being assembled, laplacians still owed by the block
    t_sample_beat sample_backlog[$];
    t_sample_beat staged[$];
    t_result      laplacian_due[$];

    // idle rates in percent, changed by the sequence between stretches
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          need_start = 1'b0;

    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned beats_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned clamp_hits = 0;
    int unsigned volumes_built = 0;
    int unsigned size_settings = 0;

    laplacian_stencil_3d_7pt_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .i_volume_start   (i_volume_start),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_laplacian      (o_laplacian),
        .o_last_of_volume (o_last_of_volume),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one printed line per mismatch, and a running count
    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // register values below 3 act as 3, above the maximum as the maximum
    function automatic int unsigned clamp_size(input logic [7:0] v, input int unsigned lim);
        if (v < 8'd3) begin
            return 3;
        end
        if (v > lim) begin
            return lim;
        end
        return 32'(v);
    endfunction

    // plane parity picks the half of the store, row and column the word
    function automatic int unsigned store_addr(input int unsigned plane, input int unsigned r,
                                               input int unsigned c);
        return (plane & 1) * PLANE_WORDS + r * MAX_Z + c;
    endfunction

    // advance the shadow stencil by one accepted sample beat and queue any laplacian it causes
    task automatic apply_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic vs);
        int unsigned sx, sy, sz, p, r, c;
        longint      centre, acc;
        t_result     res;
        sx = clamp_size(size_reg[REG_SIZE_X], MAX_X);
        sy = clamp_size(size_reg[REG_SIZE_Y], MAX_Y);
        sz = clamp_size(size_reg[REG_SIZE_Z], MAX_Z);
        if (vs) begin
            cur_plane = 0;
            cur_row = 0;
            cur_col = 0;
        end
        p = cur_plane % MAX_X;
        r = cur_row % MAX_Y;
        c = cur_col % MAX_Z;
        // the arriving sample is the upper face neighbour of centre (p-1, r, c)
        if (p >= 2 && p <= sx - 1 && r >= 1 && r + 2 <= sy && c >= 1 && c + 2 <= sz) begin
            centre = longint'(plane_mem[store_addr(p - 1, r, c)]);
            acc = longint'(plane_mem[store_addr(p - 2, r, c)]) + longint'(s)
                + longint'(plane_mem[store_addr(p - 1, r - 1, c)])
                + longint'(plane_mem[store_addr(p - 1, r + 1, c)])
                + longint'(plane_mem[store_addr(p - 1, r, c - 1)])
                + longint'(plane_mem[store_addr(p - 1, r, c + 1)])
                - 6 * centre;
            if (acc > LAP_MAX || acc < LAP_MIN) begin
                clamp_hits++;
            end
            if (acc > LAP_MAX) begin
                acc = LAP_MAX;
            end
            if (acc < LAP_MIN) begin
                acc = LAP_MIN;
            end
            res.laplacian = acc[OUT_BITS-1:0];
            res.last = (p == sx - 1 && r == sy - 2 && c == sz - 2);
            laplacian_due.push_back(res);
        end
        plane_mem[store_addr(p, r, c)] = s;
        // raster advance, wrapping to the origin after the last sample
        c++;
        if (c >= sz) begin
            c = 0;
            r++;
            if (r >= sy) begin
                r = 0;
                p++;
                if (p >= sx) begin
                    p = 0;
                end
            end
        end
        cur_plane = p;
        cur_row = r;
        cur_col = c;
    endtask

    // sample driver: holds a stalled beat, otherwise offers the next one or idles at random
    always @(posedge i_clk) begin : sample_driver
        t_sample_beat nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_sample(i_sample, i_volume_start);
                beats_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = sample_backlog.pop_front();
                    i_valid <= 1'b1;
                    i_sample <= nxt.sample;
                    i_volume_start <= nxt.volume_start;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each accepted laplacian beat against the oldest one owed
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (laplacian_due.size() == 0) begin
                    report_mismatch($sformatf("laplacian beat %0d with none owed", o_laplacian));
                end else begin
                    want = laplacian_due.pop_front();
                    if (o_laplacian !== want.laplacian) begin
                        report_mismatch($sformatf("laplacian %0d, want %0d",
                                                  o_laplacian, want.laplacian));
                    end
                    if (o_last_of_volume !== want.last) begin
                        report_mismatch($sformatf("last_of_volume %b, want %b",
                                                  o_last_of_volume, want.last));
                    end
                    beats_checked++;
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[laplacian_stencil_3d_7pt_top] ERROR");
            $finish;
        end
    end

    // one apb transfer: setup cycle, then access until pready
    task automatic apb_access(input t_reg_idx idx, input bit is_write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_reg(input t_reg_idx idx, input logic [7:0] want);
        logic [31:0] rd;
        apb_access(idx, 1'b0, 32'd0, rd);
        if (rd[7:0] !== want) begin
            report_mismatch($sformatf("%s reads %0d, want %0d", idx.name(), rd[7:0], want));
        end
    endtask

    // new sizes only once the block owes nothing and its pipeline has emptied
    task automatic write_sizes(input logic [7:0] vx, input logic [7:0] vy, input logic [7:0] vz);
        logic [31:0] rd;
        logic [7:0]  vals [3];
        while (laplacian_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        vals = '{vx, vy, vz};
        // junk in the upper data bits must not reach the 8-bit registers
        foreach (vals[k]) begin
            apb_access(t_reg_idx'(k), 1'b1, {24'($urandom), vals[k]}, rd);
            size_reg[k] = vals[k];
        end
        foreach (vals[k]) begin
            check_reg(t_reg_idx'(k), vals[k]);
        end
        size_settings++;
    endtask

    // stage one volume in raster order; some are cut short, some carry a stray start
    task automatic add_volume(input int unsigned sx, input int unsigned sy, input int unsigned sz,
                              input bit extreme_vals, input bit allow_cut, input bit force_start);
        int unsigned  total, len;
        t_sample_beat b;
        total = sx * sy * sz;
        len = total;
        if (allow_cut && $urandom_range(5) == 0) begin
            len = $urandom_range(1, total - 1);
        end
        for (int k = 0; k < len; k++) begin
            if (extreme_vals) begin
                case ($urandom_range(2))
                    0: b.sample = SAMPLE_MAX;
                    1: b.sample = SAMPLE_MIN;
                    default: b.sample = '0;
                endcase
            end else begin
                b.sample = SAMPLE_BITS'($urandom);
            end
            if (k == 0) begin
                b.volume_start = force_start || need_start || ($urandom_range(1) == 1);
            end else begin
                b.volume_start = ($urandom_range(249) == 0);
            end
            staged.push_back(b);
        end
        // a cut volume leaves the position mid-way, so the next one restarts it
        need_start = (len != total);
        volumes_built++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (sample_backlog.size() != 0 || i_valid);
    endtask

    // hand staged beats to the driver; optionally hold the sender halfway until all is back
    task automatic feed(input bit pause_midway);
        int unsigned first_part;
        first_part = pause_midway ? staged.size() / 2 : staged.size();
        @(negedge i_clk);
        for (int k = 0; k < first_part; k++) begin
            sample_backlog.push_back(staged.pop_front());
        end
        wait_drained();
        if (pause_midway) begin
            while (laplacian_due.size() != 0) @(negedge i_clk);
            while (staged.size() != 0) begin
                sample_backlog.push_back(staged.pop_front());
            end
            wait_drained();
        end
    endtask

    initial begin
        t_sample_beat b;
        logic [7:0]   rx, ry, rz;
        int unsigned  mode_beats;
        bit           first_phase;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sizes come out of reset at 128
        check_reg(REG_SIZE_X, 8'd128);
        check_reg(REG_SIZE_Y, 8'd128);
        check_reg(REG_SIZE_Z, 8'd128);

        // directed: 3x3x4 volume, x and y written below 3 so they act as 3; two interior
        // centres side by side, one driven to positive clamp and the other to negative
        write_sizes(8'd0, 8'd1, 8'd4);
        for (int k = 0; k < 36; k++) begin
            case (k)
                17: b.sample = SAMPLE_MIN;
                18: b.sample = SAMPLE_MAX;
                5, 13, 16, 21, 29: b.sample = SAMPLE_MAX;
                6, 14, 19, 22, 30: b.sample = SAMPLE_MIN;
                default: b.sample = SAMPLE_BITS'($urandom);
            endcase
            b.volume_start = (k == 0);
            staged.push_back(b);
        end
        feed(1'b0);

        // random volumes under three idling patterns: receiver-heavy, sender-heavy, none
        for (int mode = 0; mode < 3; mode++) begin
            @(negedge i_clk);
            case (mode)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 53;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            mode_beats = 0;
            first_phase = 1'b1;
            while (mode_beats < 110) begin
                rx = 8'($urandom_range(0, 6));
                ry = 8'($urandom_range(0, 6));
                rz = 8'($urandom_range(0, 6));
                write_sizes(rx, ry, rz);
                for (int v = $urandom_range(1, 3); v > 0; v--) begin
                    add_volume(clamp_size(rx, MAX_X), clamp_size(ry, MAX_Y), clamp_size(rz, MAX_Z),
                               $urandom_range(3) == 0, 1'b1, v == 0 || staged.size() == 0);
                end
                mode_beats += staged.size();
                feed(first_phase);
                first_phase = 1'b0;
            end
        end

        // wait out everything still owed, then SETTLE_CYCLES of quiet for strays
        while (laplacian_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("run: %0d sample beats in %0d volumes over %0d size settings",
                 beats_sent, volumes_built, size_settings);
        $display("run: %0d laplacian beats checked, %0d of them clamped, %0d mismatches",
                 beats_checked, clamp_hits, errors);
        if (errors == 0) begin
            $display("[laplacian_stencil_3d_7pt_top] OK");
        end else begin
            $display("[laplacian_stencil_3d_7pt_top] ERROR");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hdl
hdl/lap3d_pkg.sv
hdl/lap3d_pos.sv
hdl/lap3d_store.sv
hdl/lap3d_alu.sv
hdl/lap3d_oq.sv
hdl/laplacian_stencil_3d_7pt_top.sv
bench/tb.sv
